// File: rtl/ccmr_pkg.sv
// ============================================================================
// ccmr_pkg
// Types and constants shared by the cut-cell merge redistribution block.
// ============================================================================
package ccmr_pkg;

    localparam int VolW  = 17;
    localparam int CodeW = 4;
    localparam int UpdW  = 32;
    localparam int NComp = 4;

    localparam logic [1:0] RegGridWidth  = 2'd0;
    localparam logic [1:0] RegGridHeight = 2'd1;
    localparam logic [1:0] RegMinVolume  = 2'd2;

    typedef struct packed {
        logic [NComp-1:0][UpdW-1:0] upd;
        logic [CodeW-1:0]           code_c;
        logic [CodeW-1:0]           code_b;
        logic [CodeW-1:0]           code_a;
        logic [1:0]                 cnt;
        logic [VolW-1:0]            vol;
    } cell_t;

    localparam int CellW = $bits(cell_t);

    // Neighbor offsets for codes 0..8; codes above 8 are ignored.
    function automatic logic signed [1:0] off_i(input logic [CodeW-1:0] code);
        unique case (code)
            4'd1, 4'd4, 4'd6: off_i = -2'sd1;
            4'd3, 4'd5, 4'd8: off_i = 2'sd1;
            default:          off_i = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] off_j(input logic [CodeW-1:0] code);
        unique case (code)
            4'd1, 4'd2, 4'd3: off_j = -2'sd1;
            4'd6, 4'd7, 4'd8: off_j = 2'sd1;
            default:          off_j = 2'sd0;
        endcase
    endfunction

endpackage

// File: rtl/cut_cell_merge_redistribute.sv
// ============================================================================
// cut_cell_merge_redistribute
// Streaming 2D cut-cell merge redistribution over a three-row cell store.
// ============================================================================
// One beat is handled at a time. A beat that emits nothing leaves the block
// idle. A pass-through or covered cell goes through accept, store read, decode
// and hand-off to the output register, whose beat is valid on the next cycle. A
// merged cell also reads each in-range coded neighbor, skips out-of-range codes
// and runs four divides on one shared bit-serial divider, one per component.
// The hand-off waits while the output register still holds an unaccepted beat.
// Reset clears position counters and the output valid flag and restores register
// defaults; the row store contents are undefined until written.
module cut_cell_merge_redistribute #(
    parameter int MaxRowCells = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [16:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // volume_fraction, merge_count, neighbor_code_a, _b, _c, update_c0.._c3
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_c0.._c3
    output logic [127:0] m_tdata,
    // covered_cell, volume_error
    output logic [1:0]   m_tuser
);
    import ccmr_pkg::*;

    localparam int ColW   = $clog2(MaxRowCells);
    localparam int Depth  = 4 * MaxRowCells;
    localparam int AddrW  = $clog2(Depth);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StRead = 3'd1;
    localparam logic [2:0] StAcc  = 3'd2;
    localparam logic [2:0] StDiv  = 3'd3;
    localparam logic [2:0] StWait = 3'd4;
    localparam logic [2:0] StOut  = 3'd5;

    logic [10:0] gw_reg;
    logic [15:0] gh_reg;
    logic [16:0] minv_reg;
    logic [2:0]  st_reg, st_next;
    logic [ColW:0] x_reg, x_next;
    logic [15:0] y_reg, y_next;
    logic [1:0]  ym_reg, ym_next;
    logic [ColW:0] ew;
    logic [15:0] eh;

    logic [ColW-1:0] cx_reg, cx_next;
    logic [1:0]  cym_reg, cym_next;
    logic [1:0]  k_reg, k_next;
    logic [1:0]  comp_reg, comp_next;
    cell_t       ctr_reg, ctr_next;
    logic [18:0] svol_reg, svol_next;
    logic [NComp-1:0][50:0] supd_reg, supd_next;
    logic [NComp-1:0][31:0] res_reg, res_next;
    logic [1:0]  flg_reg, flg_next;
    logic        rd_pend_reg, rd_pend_next;
    logic        first_reg, first_next;
    logic        out_valid_reg;
    logic [127:0] out_data_reg;
    logic [1:0]  out_user_reg;

    cell_t       s_cell, rd_cell;
    logic        we;
    logic [AddrW-1:0] waddr, raddr;
    logic        div_start, div_done;
    logic [31:0] div_q;
    logic [CodeW-1:0] code_k;
    logic        code_ok;
    logic [ColW-1:0] ncx;
    logic [1:0]  ncy;
    logic signed [2:0] jj;
    logic        accept;
    logic        out_load;

    assign s_cell = cell_t'(s_tdata[CellW-1:0]);
    assign accept = s_tvalid && s_tready;
    assign s_tready = (st_reg == StIdle);
    assign out_load = (st_reg == StOut) && (!out_valid_reg || m_tready);

    always_comb
    begin
        ew = (gw_reg < 11'd3) ? (ColW+1)'(3) :
             ({21'd0, gw_reg} > MaxRowCells) ? (ColW+1)'(MaxRowCells) : (ColW+1)'(gw_reg);
        eh = (gh_reg < 16'd3) ? 16'd3 : gh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg   <= 11'd1024;
            gh_reg   <= 16'd3;
            minv_reg <= 17'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegGridWidth:  gw_reg   <= cfg_data[10:0];
                RegGridHeight: gh_reg   <= cfg_data[15:0];
                RegMinVolume:  minv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ccmr_ram #(.Width(CellW), .Depth(Depth)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (s_cell),
        .raddr (raddr),
        .rdata (rd_cell)
    );

    ccmr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (supd_reg[comp_reg]),
        .den   (svol_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    assign we    = accept && (x_reg < (ColW+1)'(MaxRowCells));
    assign waddr = {ym_reg, x_reg[ColW-1:0]};

    always_comb
    begin
        unique case (k_reg)
            2'd0:    code_k = ctr_reg.code_a;
            2'd1:    code_k = ctr_reg.code_b;
            default: code_k = ctr_reg.code_c;
        endcase
        code_ok = (code_k >= 4'd1) && (code_k <= 4'd8);
        ncx = cx_reg + ColW'(off_i(code_k));
        jj  = $signed({1'b0, cym_reg}) + 3'(off_j(code_k));
        ncy = (jj < 0) ? 2'd2 : (jj > 3'sd2) ? 2'd0 : jj[1:0];
    end

    always_comb
    begin
        st_next      = st_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        ym_next      = ym_reg;
        cx_next      = cx_reg;
        cym_next     = cym_reg;
        k_next       = k_reg;
        comp_next    = comp_reg;
        ctr_next     = ctr_reg;
        svol_next    = svol_reg;
        supd_next    = supd_reg;
        res_next     = res_reg;
        flg_next     = flg_reg;
        rd_pend_next = 1'b0;
        first_next   = first_reg;
        raddr        = {cym_reg, cx_reg};
        div_start    = 1'b0;
        unique case (st_reg)
            StIdle:
            begin
                if (accept)
                begin
                    if (x_reg >= 2 && y_reg >= 16'd2 && x_reg < ew && y_reg < eh)
                    begin
                        cx_next  = ColW'(x_reg - 1);
                        cym_next = (ym_reg == 2'd0) ? 2'd2 : ym_reg - 2'd1;
                        st_next  = StRead;
                        first_next = 1'b1;
                    end
                    if (x_reg + 1 >= ew)
                    begin
                        x_next = '0;
                        ym_next = (ym_reg == 2'd2) ? 2'd0 : ym_reg + 2'd1;
                        if (y_reg + 16'd1 >= eh)
                        begin
                            y_next = '0;
                            ym_next = 2'd0;
                        end
                        else
                        begin
                            y_next = y_reg + 16'd1;
                        end
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                    end
                end
            end
            StRead:
            begin
                raddr        = {cym_reg, cx_reg};
                rd_pend_next = 1'b1;
                k_next       = '0;
                st_next      = StAcc;
            end
            StAcc:
            begin
                raddr = {ncy, ncx};
                if (rd_pend_reg)
                begin
                    if (first_reg)
                    begin
                        first_next = 1'b0;
                        ctr_next   = rd_cell;
                        svol_next  = {2'b0, rd_cell.vol};
                        for (int n = 0; n < NComp; n++)
                        begin
                            supd_next[n] = 51'($signed({1'b0, rd_cell.vol}) *
                                           $signed(rd_cell.upd[n]));
                        end
                        if (rd_cell.vol == '0)
                        begin
                            for (int n = 0; n < NComp; n++) res_next[n] = 32'h7FFFFFFF;
                            flg_next = 2'b01;
                            st_next  = StOut;
                        end
                        else if (rd_cell.cnt == 2'd0)
                        begin
                            res_next = rd_cell.upd;
                            flg_next = 2'b00;
                            st_next  = StOut;
                        end
                        else
                        begin
                            k_next = '0;
                        end
                    end
                    else
                    begin
                        svol_next = svol_reg + {2'b0, rd_cell.vol};
                        for (int n = 0; n < NComp; n++)
                        begin
                            supd_next[n] = supd_reg[n] + 51'($signed({1'b0, rd_cell.vol}) *
                                           $signed(rd_cell.upd[n]));
                        end
                        k_next = k_reg + 2'd1;
                    end
                end
                else if (k_reg >= ctr_reg.cnt)
                begin
                    flg_next  = {svol_reg < {2'b0, minv_reg}, 1'b0};
                    comp_next = '0;
                    st_next   = StDiv;
                end
                else if (!code_ok)
                begin
                    k_next = k_reg + 2'd1;
                end
                else
                begin
                    rd_pend_next = 1'b1;
                end
            end
            StDiv:
            begin
                div_start = 1'b1;
                st_next   = StWait;
            end
            StWait:
            begin
                if (div_done)
                begin
                    res_next[comp_reg] = div_q;
                    if (comp_reg == 2'(NComp - 1))
                    begin
                        st_next = StOut;
                    end
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                        st_next   = StDiv;
                    end
                end
            end
            StOut:
            begin
                if (out_load) st_next = StIdle;
            end
            default: st_next = StIdle;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= StIdle;
            x_reg       <= '0;
            y_reg       <= '0;
            ym_reg      <= '0;
            rd_pend_reg <= 1'b0;
            first_reg   <= 1'b0;
            k_reg       <= '0;
            comp_reg    <= '0;
        end
        else
        begin
            st_reg      <= st_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            ym_reg      <= ym_next;
            rd_pend_reg <= rd_pend_next;
            first_reg   <= first_next;
            k_reg       <= k_next;
            comp_reg    <= comp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cym_reg  <= cym_next;
        ctr_reg  <= ctr_next;
        svol_reg <= svol_next;
        supd_reg <= supd_next;
        res_reg  <= res_next;
        flg_reg  <= flg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= res_reg;
            out_user_reg <= flg_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
endmodule

// File: rtl/ccmr_ram.sv
// ============================================================================
// ccmr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module ccmr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/ccmr_div.sv
// ============================================================================
// ccmr_div
// Rounded signed division of a 51-bit sum by an unsigned 19-bit volume with
// saturation, one quotient bit per cycle.
// ============================================================================
module ccmr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [50:0] num,
    input  logic [18:0] den,
    output logic        done,
    output logic [31:0] quot
);
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [52:0] mag_reg, mag_next;
    logic [19:0] rem_reg, rem_next;
    logic [52:0] q_reg, q_next;
    logic [18:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [50:0] abs_num;
    logic [20:0] trial;
    logic [19:0] rem_sh;
    logic [53:0] qf;

    assign abs_num = num[50] ? (~num + 51'd1) : num;
    assign rem_sh  = {rem_reg[18:0], mag_reg[52]};
    assign trial   = {1'b0, rem_sh} - {2'b0, den_reg};
    assign qf      = {1'b0, q_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd53;
            mag_next  = {2'b0, abs_num} + {35'd0, den[18:1]};
            rem_next  = '0;
            q_next    = '0;
            den_next  = den;
            neg_next  = num[50];
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[51:0], 1'b0};
            if (!trial[20])
            begin
                rem_next = trial[19:0];
                q_next   = {q_reg[51:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[51:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;

    always_comb
    begin
        if (neg_reg)
        begin
            if (qf >= 54'h80000000) quot = 32'h80000000;
            else                    quot = 32'd0 - q_reg[31:0];
        end
        else
        begin
            if (qf > 54'h7FFFFFFF) quot = 32'h7FFFFFFF;
            else                   quot = q_reg[31:0];
        end
    end
endmodule
